@@ design/dbfm_pkg.sv @@
// Shared widths, constants and elaboration-time root table math for the busy-fraction meter.
package dbfm_pkg;

  localparam int CLK_W               = 32;
  localparam int BUSY_W              = 24;
  localparam int DECAY_W             = 27;
  localparam int SHIFT_W             = $clog2(CLK_W);
  localparam int LEVEL_FRAC_BITS_DEF = 16;
  localparam int EXP_TABLE_BITS_DEF  = 8;
  localparam logic [CLK_W-1:0] ABSENCE_LIMIT_S = 32'd1000000;

  // Integer square root of a 64-bit value, one result bit per pass.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    x = v;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Root k of one half in Q0.32: 2^(-2^-k), each root the truncated square root of the last.
  function automatic logic [31:0] exp_root(input int k);
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int i = 1; i <= k; i++) begin
      root = isqrt64(root << 32);
    end
    return root[31:0];
  endfunction

endpackage

@@ design/dbfm_if.sv @@
// Valid/ready channel interfaces for the event input and the level result.
interface dbfm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [dbfm_pkg::CLK_W-1:0]   now_ms;
  logic [dbfm_pkg::CLK_W-1:0]   now_s;
  logic [dbfm_pkg::BUSY_W-1:0]  busy_ms;

  modport source (output valid, mode, now_ms, now_s, busy_ms, input ready);
  modport sink (input valid, mode, now_ms, now_s, busy_ms, output ready);
endinterface

interface dbfm_out_if #(parameter int LEVEL_W = dbfm_pkg::LEVEL_FRAC_BITS_DEF);
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

@@ design/decaying_busy_fraction_meter.sv @@
// Top level of the decaying busy-fraction meter: event sequencer, state and output register.
//
// Usage: each transaction on in_if is one event. mode 0 starts tracking: the level
// clears and the millisecond and second clocks are recorded. mode 1 reports a command
// that kept the unit busy for busy_ms: the level first decays over the idle gap since
// the last event, then is charged toward one for the busy time, with a half-life of
// decay_ms. Every event returns exactly one transaction on out_if carrying the level
// after the event as unsigned Q0.LEVEL_FRAC_BITS, saturated just below one.
// decay_ms is written through cfg_we/cfg_wdata; the user must do so only while no event
// is in flight, as the block does not enforce it. While decay_ms is zero, update events
// leave the level and clocks untouched and just report it. A start event or a disabled
// update goes from idle through the prepare state to done and into the output register.
// Each scaling (decay, then charge) runs the shared divider, which produces
// 32+EXP_TABLE_BITS quotient bits one per cycle, then the shared multiplier, which
// takes one root per cycle and then scales the value. An update runs the decay only
// for a nonzero gap and the charge only for nonzero busy time. One event is in work at
// a time; in_if.ready is high only while the sequencer is idle.
// Reset clears the level, the recorded clocks and decay_ms. If out_if is stalled, the
// finished level waits in the output register; a further event may be accepted, and
// its result is held back until the previous one has been taken.
module decaying_busy_fraction_meter #(
  parameter int LEVEL_FRAC_BITS = dbfm_pkg::LEVEL_FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS  = dbfm_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dbfm_in_if.sink                       in_if,
  dbfm_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [dbfm_pkg::DECAY_W-1:0]  cfg_wdata
);
  import dbfm_pkg::*;

  localparam int F = LEVEL_FRAC_BITS;
  localparam int E = EXP_TABLE_BITS;
  localparam int N = CLK_W + E;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_CHG  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_POW  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [DECAY_W-1:0] decay_r;
  logic [F-1:0]       level_r;
  logic [CLK_W-1:0]   last_ms_r;
  logic [CLK_W-1:0]   last_s_r;

  // Captured event fields.
  logic               mode_r;
  logic [CLK_W-1:0]   now_ms_r;
  logic [CLK_W-1:0]   now_s_r;
  logic [BUSY_W-1:0]  busy_r;

  // Working value during an event; it can reach exactly one after a full charge.
  logic [F:0]         work_r;
  logic [CLK_W-1:0]   q_r;
  logic               phase_chg_r;

  logic               out_valid_r;
  logic [F-1:0]       out_level_r;

  logic [CLK_W-1:0]   ds;
  logic [CLK_W-1:0]   gap;
  logic               absent;
  logic               busy_nz;
  logic               div_start;
  logic [N-1:0]       div_dividend;
  logic               div_busy;
  logic               div_done;
  logic [N-1:0]       div_quot;
  logic               pow_start;
  logic               pow_done;
  logic [F:0]         pow_scaled;
  logic [F:0]         shifted;
  logic [F-1:0]       sat_level;
  logic               accept;
  logic               out_load;

  assign accept   = in_if.valid && in_if.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  // The seconds-clock difference wraps; a step backward (top bit set) never counts as absence.
  assign ds      = now_s_r - last_s_r;
  assign absent  = (ds > ABSENCE_LIMIT_S) && !ds[CLK_W-1];
  assign gap     = now_ms_r - CLK_W'(busy_r) - last_ms_r;
  assign busy_nz = busy_r != '0;

  // The divider computes floor(x * 2^E / decay): whole half-lives above, fraction below.
  assign div_start    = ((state_r == S_PREP) && mode_r && (decay_r != '0) && !absent
                         && (gap != '0))
                     || ((state_r == S_CHG) && busy_nz);
  assign div_dividend = (state_r == S_PREP) ? {gap, {E{1'b0}}}
                                            : {CLK_W'(busy_r), {E{1'b0}}};
  assign pow_start    = (state_r == S_DIV) && div_done;

  // Thirty-two or more whole half-lives leave nothing.
  assign shifted   = (q_r[CLK_W-1:SHIFT_W] != '0) ? '0 : (pow_scaled >> q_r[SHIFT_W-1:0]);
  assign sat_level = work_r[F] ? {F{1'b1}} : work_r[F-1:0];

  dbfm_div #(
    .EXP_TABLE_BITS (E)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (decay_r),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  dbfm_pow #(
    .LEVEL_FRAC_BITS (F),
    .EXP_TABLE_BITS  (E)
  ) u_pow (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (pow_start),
    .frac   (div_quot[E-1:0]),
    .value  (work_r),
    .done   (pow_done),
    .scaled (pow_scaled)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_PREP;
      S_PREP: begin
        if (!mode_r || (decay_r == '0)) begin
          state_nxt = S_DONE;
        end else if (div_start) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_CHG;
        end
      end
      S_CHG:  state_nxt = busy_nz ? S_DIV : S_FIN;
      S_DIV:  if (div_done) state_nxt = S_POW;
      S_POW:  if (pow_done) state_nxt = phase_chg_r ? S_FIN : S_CHG;
      S_FIN:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      decay_r     <= '0;
      level_r     <= '0;
      last_ms_r   <= '0;
      last_s_r    <= '0;
      phase_chg_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        decay_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_PREP) && !mode_r) begin
        level_r   <= '0;
        last_ms_r <= now_ms_r;
        last_s_r  <= now_s_r;
      end
      if (state_r == S_FIN) begin
        level_r   <= sat_level;
        last_ms_r <= now_ms_r;
        last_s_r  <= now_s_r;
      end
      if (state_r == S_PREP) begin
        phase_chg_r <= 1'b0;
      end else if (state_r == S_CHG) begin
        phase_chg_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_if.mode;
      now_ms_r <= in_if.now_ms;
      now_s_r  <= in_if.now_s;
      busy_r   <= in_if.busy_ms;
    end
    if (state_r == S_PREP) begin
      work_r <= absent ? '0 : {1'b0, level_r};
    end else if ((state_r == S_CHG) && busy_nz) begin
      // Charging scales the idle complement, then complements it back.
      work_r <= ONE - work_r;
    end else if ((state_r == S_POW) && pow_done) begin
      work_r <= phase_chg_r ? (ONE - shifted) : shifted;
    end
    if (pow_start) begin
      q_r <= div_quot[N-1:E];
    end
    if (out_load) begin
      out_level_r <= level_r;
    end
  end

  assign in_if.ready  = state_r == S_IDLE;
  assign out_if.valid = out_valid_r;
  assign out_if.level = out_level_r;

`ifndef SYNTHESIS
  a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_if.ready)
    else $error("second event accepted while one is in work");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_work_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (work_r <= ONE))
    else $error("working level above one before saturation");

  a_clock_update: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(last_ms_r) |-> ($past(state_r) == S_PREP) || ($past(state_r) == S_FIN))
    else $error("recorded clock changed outside event completion");
`endif

endmodule

@@ design/dbfm_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module dbfm_div #(
  parameter int EXP_TABLE_BITS = dbfm_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            start,
  input  logic [dbfm_pkg::CLK_W+EXP_TABLE_BITS-1:0]       dividend,
  input  logic [dbfm_pkg::DECAY_W-1:0]                    divisor,
  output logic                                            busy,
  output logic                                            done,
  output logic [dbfm_pkg::CLK_W+EXP_TABLE_BITS-1:0]       quot
);
  import dbfm_pkg::*;

  localparam int N     = CLK_W + EXP_TABLE_BITS;
  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]       quo_r;
  logic [DECAY_W-1:0] rem_r;
  logic [DECAY_W-1:0] divisor_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               active_r;
  logic               done_r;
  logic [DECAY_W:0]   trial;
  logic               ge;

  // The dividend shifts out of the top of quo_r while quotient bits enter at the bottom.
  assign trial = {rem_r, quo_r[N-1]};
  assign ge    = trial >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= CNT_W'(N);
      end else if (active_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (active_r) begin
      rem_r <= ge ? DECAY_W'(trial - {1'b0, divisor_r}) : trial[DECAY_W-1:0];
      quo_r <= {quo_r[N-2:0], ge};
    end
  end

  assign busy = active_r;
  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ design/dbfm_pow.sv @@
// Fractional power-of-two scaler: builds 2^(-f/2^E) from a root table, then multiplies the value.
module dbfm_pow #(
  parameter int LEVEL_FRAC_BITS = dbfm_pkg::LEVEL_FRAC_BITS_DEF,
  parameter int EXP_TABLE_BITS  = dbfm_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [EXP_TABLE_BITS-1:0]   frac,
  input  logic [LEVEL_FRAC_BITS:0]    value,
  output logic                        done,
  output logic [LEVEL_FRAC_BITS:0]    scaled
);
  import dbfm_pkg::*;

  localparam int F      = LEVEL_FRAC_BITS;
  localparam int E      = EXP_TABLE_BITS;
  localparam int STEP_W = $clog2(E + 1);
  localparam int IDX_W  = $clog2(E);
  localparam int M_W    = CLK_W + 1;
  localparam int P_W    = M_W + CLK_W;

  logic [CLK_W-1:0] root_tbl [E];

  for (genvar k = 0; k < E; k++) begin : g_root
    localparam logic [CLK_W-1:0] ROOT_VAL = exp_root(k + 1);
    assign root_tbl[k] = ROOT_VAL;
  end

  logic              active_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [E-1:0]      frac_r;
  logic [F:0]        value_r;
  logic [M_W-1:0]    m_r;
  logic [F:0]        scaled_r;
  logic              last_step;
  logic [CLK_W-1:0]  mul_b;
  logic [P_W-1:0]    prod;

  assign last_step = step_r == STEP_W'(E);
  // One multiplier serves the root steps and the final scaling of the value.
  assign mul_b = last_step ? CLK_W'(value_r) : root_tbl[step_r[IDX_W-1:0]];
  assign prod  = P_W'(m_r) * P_W'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        step_r   <= '0;
      end else if (active_r) begin
        if (last_step) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end else begin
          step_r <= step_r + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      frac_r  <= frac;
      value_r <= value;
      m_r     <= {1'b1, {CLK_W{1'b0}}};
    end else if (active_r) begin
      if (last_step) begin
        scaled_r <= prod[CLK_W+F:CLK_W];
      end else begin
        // Fraction bits are consumed most significant first, one root per cycle.
        if (frac_r[E-1]) begin
          m_r <= prod[P_W-1:CLK_W];
        end
        frac_r <= frac_r << 1;
      end
    end
  end

  assign done   = done_r;
  assign scaled = scaled_r;

endmodule
